// File: src/bts_pkg.sv
`default_nettype none
package bts_pkg;

	// configuration register indexes (paddr = 4 * index)
	localparam logic [1:0] REG_PC_STORE_OFFSET = 2'd0;
	localparam logic [1:0] REG_ALIGN_FAULT_EN  = 2'd1;
	localparam logic [1:0] REG_BASE_RESTORED   = 2'd2;

	localparam logic [3:0] PC_STORE_OFFSET_RST = 4'd8;

	// end action codes
	localparam logic [1:0] ACT_NEXT       = 2'd0;
	localparam logic [1:0] ACT_PC_LOAD    = 2'd1;
	localparam logic [1:0] ACT_EXC_RETURN = 2'd2;

	localparam logic [3:0]  PC_REG     = 4'd15;
	localparam logic [31:0] WORD_BYTES = 32'd4;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch a new instruction
		logic step;      // single result, or one walk step over the list
		logic emit_base; // emit the deferred base register load
	} bts_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // output register can take a beat
		logic single;    // fault or empty list: one result only
		logic rem_last;  // one register left in the walk
		logic defer;     // base register load goes last
	} bts_status_t;

endpackage
`default_nettype wire

// File: src/block_transfer_sequencer.sv
`default_nettype none
// Load/store-multiple address sequencer.
// Sequence: accept loads the instruction registers, then one walk step per listed register,
// then one deferred beat when a loaded base is deferred (its own walk step emits nothing);
// a fault or empty list gives a single result. A new instruction is taken only when idle.
// A beat that waits on out_ready stalls the walk.
// Reset (arst_n low, async): sequencer idle, output empty, registers at 8 / 1 / 0.
module block_transfer_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// instruction channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] reg_list,
	input  wire logic [3:0]  base_reg,
	input  wire logic [31:0] base_value,
	input  wire logic        pre_index,
	input  wire logic        up,
	input  wire logic        write_back,
	input  wire logic        is_load,
	input  wire logic        s_bit,
	input  wire logic [31:0] insn_address,
	// access channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             access_valid,
	output logic [31:0]      access_address,
	output logic [3:0]       reg_index,
	output logic             access_is_load,
	output logic             user_bank,
	output logic [31:0]      stored_pc_value,
	output logic             fault,
	output logic             writeback_enable,
	output logic [31:0]      writeback_value,
	output logic [1:0]       end_action,
	output logic             last
);
	import bts_pkg::*;

	// configuration registers
	logic [3:0] pc_store_offset_q;
	logic       align_fault_enable_q;
	logic       base_restored_q;
	logic       cfg_wr;
	logic [1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_store_offset_q    <= PC_STORE_OFFSET_RST;
			align_fault_enable_q <= 1'b1;
			base_restored_q      <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PC_STORE_OFFSET: pc_store_offset_q    <= pwdata[3:0];
				REG_ALIGN_FAULT_EN:  align_fault_enable_q <= pwdata[0];
				REG_BASE_RESTORED:   base_restored_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (cfg_idx)
			REG_PC_STORE_OFFSET: prdata = {28'd0, pc_store_offset_q};
			REG_ALIGN_FAULT_EN:  prdata = {31'd0, align_fault_enable_q};
			REG_BASE_RESTORED:   prdata = {31'd0, base_restored_q};
			default:             prdata = 32'd0;
		endcase
	end

	bts_cmd_t    cmd;
	bts_status_t status;

	bts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	bts_dp u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.status                 (status),
		.pc_store_offset        (pc_store_offset_q),
		.align_fault_enable     (align_fault_enable_q),
		.base_restored_on_abort (base_restored_q),
		.reg_list               (reg_list),
		.base_reg               (base_reg),
		.base_value             (base_value),
		.pre_index              (pre_index),
		.up                     (up),
		.write_back             (write_back),
		.is_load                (is_load),
		.s_bit                  (s_bit),
		.insn_address           (insn_address),
		.out_ready              (out_ready),
		.out_valid              (out_valid),
		.access_valid           (access_valid),
		.access_address         (access_address),
		.reg_index              (reg_index),
		.access_is_load         (access_is_load),
		.user_bank              (user_bank),
		.stored_pc_value        (stored_pc_value),
		.fault                  (fault),
		.writeback_enable       (writeback_enable),
		.writeback_value        (writeback_value),
		.end_action             (end_action),
		.last                   (last)
	);

endmodule
`default_nettype wire

// File: src/bts_ctrl.sv
`default_nettype none
module bts_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire bts_pkg::bts_status_t status,
	output logic                    in_ready,
	output bts_pkg::bts_cmd_t       cmd
);
	import bts_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_BASE
	} state_t;

	state_t state_q;

	// commands decoded from state
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.step      = (state_q == ST_WALK) && status.out_free;
		cmd.emit_base = (state_q == ST_BASE) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (status.out_free && (status.single || status.rem_last)) begin
						state_q <= (status.defer && !status.single) ? ST_BASE : ST_IDLE;
					end
				end
				ST_BASE: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/bts_dp.sv
`default_nettype none
module bts_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bts_pkg::bts_cmd_t  cmd,
	output bts_pkg::bts_status_t    status,
	// configuration
	input  wire logic [3:0]         pc_store_offset,
	input  wire logic               align_fault_enable,
	input  wire logic               base_restored_on_abort,
	// instruction
	input  wire logic [15:0]        reg_list,
	input  wire logic [3:0]         base_reg,
	input  wire logic [31:0]        base_value,
	input  wire logic               pre_index,
	input  wire logic               up,
	input  wire logic               write_back,
	input  wire logic               is_load,
	input  wire logic               s_bit,
	input  wire logic [31:0]        insn_address,
	// result beat
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic                    access_valid,
	output logic [31:0]             access_address,
	output logic [3:0]              reg_index,
	output logic                    access_is_load,
	output logic                    user_bank,
	output logic [31:0]             stored_pc_value,
	output logic                    fault,
	output logic                    writeback_enable,
	output logic [31:0]             writeback_value,
	output logic [1:0]              end_action,
	output logic                    last
);
	import bts_pkg::*;

	// instruction decode at load
	logic [4:0]  cnt;
	logic [31:0] span, off, start_addr, wbv;
	logic        pc_in, exc_ret, user_mode, rn_in, defer_in, do_wb, misaligned, fault_in;
	logic [1:0]  act_in;

	always_comb begin
		cnt = '0;
		for (int i = 0; i < 16; i++) cnt = cnt + {4'd0, reg_list[i]};
		span      = {25'd0, cnt, 2'b00};
		off       = up ? 32'd0 : (32'd0 - span);
		if (pre_index == up) off = off + WORD_BYTES;
		start_addr = base_value + off;
		wbv       = up ? (base_value + span) : (base_value - span);
		pc_in     = reg_list[PC_REG];
		exc_ret   = s_bit && is_load && pc_in;
		user_mode = s_bit && !exc_ret;
		rn_in     = reg_list[base_reg];
		defer_in  = is_load && rn_in;
		do_wb     = write_back && !defer_in;
		act_in    = (is_load && pc_in) ? (exc_ret ? ACT_EXC_RETURN : ACT_PC_LOAD) : ACT_NEXT;
		misaligned = (start_addr[1:0] != 2'b00);
		fault_in  = misaligned && align_fault_enable;
	end

	// per-instruction registers
	logic [15:0] rem_q;
	logic [3:0]  rn_q;
	logic [31:0] addr_q, rn_addr_q, wbv_q, pc_q;
	logic        wbe_q, load_q, user_q, defer_q, fault_q, single_q;
	logic [1:0]  act_q;

	// walk step: lowest remaining register
	logic [15:0] low_onehot, rem_next;
	logic [3:0]  low_idx;
	logic        skip, walk_last;

	always_comb begin
		low_onehot = rem_q & (~rem_q + 16'd1);
		low_idx    = '0;
		for (int i = 0; i < 16; i++) begin
			if (low_onehot[i]) low_idx = 4'(i);
		end
		rem_next  = rem_q & ~low_onehot;
		skip      = defer_q && (low_idx == rn_q);
		walk_last = (rem_next == 16'd0) && !defer_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q    <= reg_list;
			rn_q     <= base_reg;
			addr_q   <= fault_in ? start_addr : {start_addr[31:2], 2'b00};
			wbv_q    <= wbv;
			pc_q     <= insn_address;
			wbe_q    <= do_wb && !(fault_in && base_restored_on_abort);
			load_q   <= is_load;
			user_q   <= user_mode;
			defer_q  <= defer_in;
			fault_q  <= fault_in;
			single_q <= fault_in || (reg_list == 16'd0);
			act_q    <= act_in;
		end else if (cmd.step && !single_q) begin
			rem_q  <= rem_next;
			addr_q <= addr_q + WORD_BYTES;
			if (skip) rn_addr_q <= addr_q;
		end
	end

	// output register
	logic out_valid_q;
	logic emit;
	assign emit = cmd.emit_base || (cmd.step && (single_q || !skip));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (cmd.emit_base) begin
				access_valid     <= 1'b1;
				access_address   <= rn_addr_q;
				reg_index        <= rn_q;
				access_is_load   <= 1'b1;
				user_bank        <= user_q;
				stored_pc_value  <= '0;
				fault            <= 1'b0;
				writeback_enable <= wbe_q;
				writeback_value  <= wbv_q;
				end_action       <= act_q;
				last             <= 1'b1;
			end else if (single_q) begin
				// fault or empty list
				access_valid     <= 1'b0;
				access_address   <= fault_q ? addr_q : 32'd0;
				reg_index        <= '0;
				access_is_load   <= fault_q && load_q;
				user_bank        <= 1'b0;
				stored_pc_value  <= '0;
				fault            <= fault_q;
				writeback_enable <= wbe_q;
				writeback_value  <= wbv_q;
				end_action       <= ACT_NEXT;
				last             <= 1'b1;
			end else begin
				access_valid     <= 1'b1;
				access_address   <= addr_q;
				reg_index        <= low_idx;
				access_is_load   <= load_q;
				user_bank        <= user_q;
				stored_pc_value  <= (!load_q && low_idx == PC_REG)
					? pc_q + {28'd0, pc_store_offset} : 32'd0;
				fault            <= 1'b0;
				writeback_enable <= walk_last && wbe_q;
				writeback_value  <= walk_last ? wbv_q : 32'd0;
				end_action       <= walk_last ? act_q : ACT_NEXT;
				last             <= walk_last;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		status.out_free = !out_valid_q || out_ready;
		status.single   = single_q;
		status.rem_last = (rem_next == 16'd0);
		status.defer    = defer_q;
	end

endmodule
`default_nettype wire
